>>> hw/rtl/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared widths and stream layout for the 4x4 matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

  localparam int INDEX_W = 4;   // flat element / product index
  localparam int ELEM_W  = 32;  // signed fixed-point element

  // Input tdata: element_index, left_element, right_element, byte padded.
  localparam int IN_FIELDS_W = INDEX_W + 2 * ELEM_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

  // Output tdata: product_index, product_element, byte padded.
  localparam int OUT_FIELDS_W = INDEX_W + ELEM_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic [INDEX_W-1:0] index_t;
  typedef logic signed [ELEM_W-1:0] elem_t;

endpackage

>>> hw/rtl/mm4_ram.sv
// ----------------------------------------------------------------------------
// mm4_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data while no read is issued
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/matrix4x4_multiply.sv
// ----------------------------------------------------------------------------
// matrix4x4_multiply
// Column-major square matrix product in signed fixed point, streamed in and out.
// ----------------------------------------------------------------------------
// Each input beat stores one left and one right element at a flat column-major
// index (column*MATRIX_DIM+row); indexes beyond the matrix are not stored. A
// beat with in_tlast set stores its elements and then starts the product: the
// block emits MATRIX_DIM*MATRIX_DIM result beats in column-major order, the
// final one with out_tlast set. Each result is the sum over k of
// left(row,k)*right(k,col), every 64-bit term shifted right arithmetically by
// FRACTION_BITS (rounds toward minus infinity), summed exactly and saturated
// to 32 bits. While idle, a load beat is taken every cycle. Both matrices live
// in one RAM each with a single read port, so the product is computed one
// multiply-accumulate step per cycle while the output is not stalled;
// in_tready stays low until the last result has left the multiply pipeline.
// Output back-pressure freezes the multiply pipeline. After reset both
// matrices read as zero: a valid bit per entry masks entries never written.
// ----------------------------------------------------------------------------
module matrix4x4_multiply #(
  parameter int MATRIX_DIM    = 4,
  parameter int FRACTION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [3:0] element_index, [35:4] left_element, [67:36] right_element, rest zero
  input  logic [mm4_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tlast,   // compute_now
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [3:0] product_index, [35:4] product_element, rest zero
  output logic [mm4_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast   // last_product
);

  localparam int CELLS  = MATRIX_DIM * MATRIX_DIM;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int DIM_W  = $clog2(MATRIX_DIM);
  localparam int PROD_W = 2 * mm4_pkg::ELEM_W;
  // exact sum of MATRIX_DIM shifted 64-bit terms
  localparam int ACC_W  = PROD_W + DIM_W + 1;

  localparam logic [DIM_W-1:0]  DIM_LAST  = DIM_W'(MATRIX_DIM - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] DIM_A     = ADDR_W'(MATRIX_DIM);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

  // ---------------------------------------------------------------- input side
  mm4_pkg::index_t in_index;
  mm4_pkg::elem_t  in_left;
  mm4_pkg::elem_t  in_right;
  logic            in_beat;
  logic            wr_en;
  logic [ADDR_W-1:0] wr_addr;

  assign in_index = in_tdata[mm4_pkg::INDEX_W-1:0];
  assign in_left  = in_tdata[mm4_pkg::INDEX_W +: mm4_pkg::ELEM_W];
  assign in_right = in_tdata[mm4_pkg::INDEX_W + mm4_pkg::ELEM_W +: mm4_pkg::ELEM_W];

  assign in_beat = in_tvalid && in_tready;
  // drop stores that fall outside the matrix
  assign wr_en   = in_beat && (32'(in_index) < 32'(CELLS));
  assign wr_addr = ADDR_W'(in_index);

  // ------------------------------------------------------------ control regs
  logic              busy_r;
  logic [DIM_W-1:0]  k_r, row_r, col_r;
  logic              s1_vld_r, s1_first_r, s1_last_r, s1_lok_r, s1_rok_r;
  logic [ADDR_W-1:0] s1_pos_r;
  logic              s2_vld_r, s2_first_r, s2_last_r;
  logic [ADDR_W-1:0] s2_pos_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic              out_valid_r;
  mm4_pkg::index_t   out_index_r;
  mm4_pkg::elem_t    out_elem_r;
  logic              out_last_r;
  logic [CELLS-1:0]  lok_r, rok_r;

  logic              adv;     // pipeline advance
  logic              issue;   // read both memories this cycle
  logic [ADDR_W-1:0] rd_addr_lft, rd_addr_rgt, pos;

  // freeze the sequencer and the pipeline while a finished result waits
  assign adv   = !out_valid_r || out_tready;
  assign issue = busy_r && adv;

  // accept loads only once the previous product has left the pipeline
  assign in_tready = !busy_r && !s1_vld_r && !s2_vld_r;

  assign rd_addr_lft = ADDR_W'(k_r) * DIM_A + ADDR_W'(row_r);
  assign rd_addr_rgt = ADDR_W'(col_r) * DIM_A + ADDR_W'(k_r);
  assign pos         = ADDR_W'(col_r) * DIM_A + ADDR_W'(row_r);

  // ------------------------------------------------------------ element store
  logic [mm4_pkg::ELEM_W-1:0] l_rdata, r_rdata;

  mm4_ram #(.WIDTH(mm4_pkg::ELEM_W), .DEPTH(CELLS)) u_left_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_left),
    .re    (issue),
    .raddr (rd_addr_lft),
    .rdata (l_rdata)
  );

  mm4_ram #(.WIDTH(mm4_pkg::ELEM_W), .DEPTH(CELLS)) u_right_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_right),
    .re    (issue),
    .raddr (rd_addr_rgt),
    .rdata (r_rdata)
  );

  // Entry-written flags; an unwritten entry reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lok_r <= '0;
      rok_r <= '0;
    end else if (wr_en) begin
      lok_r[wr_addr] <= 1'b1;
      rok_r[wr_addr] <= 1'b1;
    end
  end

  // --------------------------------------------------------------- sequencer
  // Walk col, row, k with k innermost: one multiply-accumulate step per cycle while the output is not stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
      row_r  <= '0;
      col_r  <= '0;
    end else if (in_beat && in_tlast) begin
      busy_r <= 1'b1;
      k_r    <= '0;
      row_r  <= '0;
      col_r  <= '0;
    end else if (issue) begin
      if (k_r != DIM_LAST) begin
        k_r <= k_r + 1'b1;
      end else begin
        k_r <= '0;
        if (row_r != DIM_LAST) begin
          row_r <= row_r + 1'b1;
        end else begin
          row_r <= '0;
          if (col_r != DIM_LAST) begin
            col_r <= col_r + 1'b1;
          end else begin
            col_r  <= '0;
            busy_r <= 1'b0;
          end
        end
      end
    end
  end

  // ---------------------------------------------------- stage 1: read return
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_first_r <= (k_r == '0);
      s1_last_r  <= (k_r == DIM_LAST);
      s1_pos_r   <= pos;
      s1_lok_r   <= lok_r[rd_addr_lft];
      s1_rok_r   <= rok_r[rd_addr_rgt];
    end
  end

  // ---------------------------------------------------- stage 2: multiply
  mm4_pkg::elem_t op_l, op_r;

  assign op_l = s1_lok_r ? mm4_pkg::elem_t'(l_rdata) : '0;
  assign op_r = s1_rok_r ? mm4_pkg::elem_t'(r_rdata) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_vld_r) begin
      s2_prod_r  <= PROD_W'(op_l) * PROD_W'(op_r);
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      s2_pos_r   <= s1_pos_r;
    end
  end

  // ------------------------------------------- stage 3: accumulate, saturate
  logic signed [PROD_W-1:0] term;
  logic signed [ACC_W-1:0]  acc_nxt;
  mm4_pkg::elem_t           sat_val;

  assign term    = s2_prod_r >>> FRACTION_BITS;
  assign acc_nxt = (s2_first_r ? '0 : acc_r) + ACC_W'(term);

  always_comb begin
    if (acc_nxt > SAT_HI) begin
      sat_val = 32'sh7fffffff;
    end else if (acc_nxt < SAT_LO) begin
      sat_val = 32'sh80000000;
    end else begin
      sat_val = acc_nxt[mm4_pkg::ELEM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  // ---------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_vld_r && s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_vld_r && s2_last_r) begin
      out_index_r <= mm4_pkg::INDEX_W'(s2_pos_r);
      out_elem_r  <= sat_val;
      out_last_r  <= (s2_pos_r == CELL_LAST);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(mm4_pkg::OUT_TDATA_W - mm4_pkg::OUT_FIELDS_W){1'b0}},
                       out_elem_r, out_index_r};
  assign out_tlast  = out_last_r;

endmodule

>>> hw/rtl/mm4_chk.sv
// ----------------------------------------------------------------------------
// mm4_chk
// Port-level checks for the matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module mm4_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mm4_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result payload changed while stalled");

  // a compute beat is followed by in_tready low
  a_busy_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input accepted right after a compute beat");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind matrix4x4_multiply mm4_chk u_mm4_chk (.*);
